// ===== hdl/sql_like_wildcard_matcher_macros.svh =====
// Assertion helpers for the LIKE matcher
`ifndef SQL_LIKE_WILDCARD_MATCHER_MACROS_SVH
`define SQL_LIKE_WILDCARD_MATCHER_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define SLWM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define SLWM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/slwm_pkg.sv =====
package slwm_pkg;

    localparam int MaxElementsDef = 32;
    localparam int CpW = 21;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PAT   = 2'd1;
    localparam logic [1:0] MODE_SUBJ  = 2'd2;
    localparam logic [1:0] MODE_END   = 2'd3;

    localparam logic [1:0] KIND_LIT = 2'd0;
    localparam logic [1:0] KIND_ONE = 2'd1;
    localparam logic [1:0] KIND_RUN = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_ESC = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam logic [CpW-1:0] CH_RUN = 21'h25;
    localparam logic [CpW-1:0] CH_ONE = 21'h5F;
    localparam logic [CpW-1:0] CH_ESC = 21'h5C;

    typedef struct packed {
        logic [1:0]     mode;
        logic [CpW-1:0] code_point;
    } in_item_t;

    typedef struct packed {
        logic       matched;
        logic [1:0] status;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic           clear;
        logic           pat;
        logic           subj;
        logic           fin;
        logic [CpW-1:0] cp;
    } dp_cmd_t;

endpackage

// ===== hdl/sql_like_wildcard_matcher.sv =====
// Channel   Ports                         Transaction
// input     s_valid s_ready s_data        mode and code point
// output    m_valid m_ready m_data        matched and status
// Each accepted item is applied as it is taken; the per-element cell array updates all
// active positions at once. A subject end's result is registered and shows
// the cycle after acceptance. Input stalls only while a result waits and
// m_ready is low. Synchronous active-low reset empties the pattern.
module sql_like_wildcard_matcher #(
    parameter int MAX_ELEMENTS = slwm_pkg::MaxElementsDef
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  slwm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output slwm_pkg::out_item_t m_data
);
    import slwm_pkg::*;
    `include "sql_like_wildcard_matcher_macros.svh"

    dp_cmd_t   cmd;
    out_item_t result;

    slwm_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cmd, .result
    );

    slwm_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .aclk, .aresetn, .cmd, .result
    );

    `SLWM_ASSERT_IMP(a_match_ok, aclk, aresetn, m_valid && m_data.matched, m_data.status == STAT_OK)
    `SLWM_ASSERT_NEXT(a_end_gives_result, aclk, aresetn, cmd.fin, m_valid)
    `SLWM_ASSERT_IMP(a_ready_free, aclk, aresetn, !m_valid, s_ready)

endmodule

// ===== hdl/slwm_datapath.sv =====
module slwm_datapath #(
    parameter int MAX_ELEMENTS = slwm_pkg::MaxElementsDef
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  slwm_pkg::dp_cmd_t   cmd,
    output slwm_pkg::out_item_t result
);
    import slwm_pkg::*;

    localparam int LenW = $clog2(MAX_ELEMENTS + 1);
    localparam int IdxW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    // Element store: one cell per element, each read at its own place
    logic [1:0]     kind_reg [MAX_ELEMENTS];
    logic [CpW-1:0] lit_reg  [MAX_ELEMENTS];
    logic [LenW-1:0] len_reg, len_next;
    logic            esc_reg, esc_next;
    logic [1:0]      stat_reg, stat_next;
    logic [MAX_ELEMENTS:0] act_reg, act_next;
    logic            insub_reg, insub_next;

    logic       add_en;
    logic [1:0] add_kind;
    logic       wr_en;
    logic [MAX_ELEMENTS:0] base, stepped, closed;
    logic [MAX_ELEMENTS-1:0] used;
    logic       last_run;

    // Mask of stored elements and kind of the last one
    always_comb begin
        last_run = 1'b0;
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            used[i] = (LenW'(i) < len_reg);
            if (LenW'(i + 1) == len_reg && kind_reg[i] == KIND_RUN) last_run = 1'b1;
        end
    end

    // Pattern compiler
    always_comb begin
        add_en    = 1'b0;
        add_kind  = KIND_LIT;
        esc_next  = esc_reg;
        stat_next = stat_reg;
        if (cmd.pat && stat_reg == STAT_OK) begin
            if (esc_reg) begin
                esc_next = 1'b0;
                if (cmd.cp == CH_RUN || cmd.cp == CH_ONE) add_en = 1'b1;
                else stat_next = STAT_BAD_ESC;
            end else if (cmd.cp == CH_ESC) begin
                esc_next = 1'b1;
            end else begin
                add_en = 1'b1;
                if (cmd.cp == CH_RUN) add_kind = KIND_RUN;
                else if (cmd.cp == CH_ONE) add_kind = KIND_ONE;
            end
        end
        wr_en    = 1'b0;
        len_next = len_reg;
        if (add_en && !(add_kind == KIND_RUN && last_run)) begin
            if (len_reg >= LenW'(MAX_ELEMENTS)) stat_next = STAT_FULL;
            else begin
                wr_en    = 1'b1;
                len_next = len_reg + 1'b1;
            end
        end
        if (cmd.clear) begin
            len_next  = '0;
            esc_next  = 1'b0;
            stat_next = STAT_OK;
        end
    end

    // Cell array: advance active positions, then pass through runs
    always_comb begin
        base = insub_reg ? act_reg : (MAX_ELEMENTS + 1)'(1);
        stepped = '0;
        if (!insub_reg) begin
            stepped = base;
        end else begin
            for (int i = 0; i < MAX_ELEMENTS; i++) begin
                if (base[i] && used[i]) begin
                    if (kind_reg[i] == KIND_RUN) stepped[i] = 1'b1;
                    else if (kind_reg[i] == KIND_ONE || lit_reg[i] == cmd.cp)
                        stepped[i+1] = 1'b1;
                end
            end
        end
        closed = stepped;
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            if (closed[i] && used[i] && kind_reg[i] == KIND_RUN) closed[i+1] = 1'b1;
        end
    end

    // Subject tracking
    always_comb begin
        act_next   = act_reg;
        insub_next = insub_reg;
        if (cmd.clear || cmd.pat || cmd.fin) begin
            act_next   = '0;
            insub_next = 1'b0;
        end else if (cmd.subj) begin
            if (!insub_reg) begin
                // fresh subject: closure of the start position, one step, then pass through runs
                act_next = '0;
                for (int i = 0; i < MAX_ELEMENTS; i++) begin
                    if (closed[i] && used[i]) begin
                        if (kind_reg[i] == KIND_RUN) act_next[i] = 1'b1;
                        else if (kind_reg[i] == KIND_ONE || lit_reg[i] == cmd.cp)
                            act_next[i+1] = 1'b1;
                    end
                end
                for (int i = 0; i < MAX_ELEMENTS; i++) begin
                    if (act_next[i] && used[i] && kind_reg[i] == KIND_RUN)
                        act_next[i+1] = 1'b1;
                end
            end else begin
                act_next = closed;
            end
            insub_next = 1'b1;
        end
    end

    // Result of a subject end: held positions, or the start closure if no subject
    always_comb begin
        result.status  = stat_reg;
        result.matched = (stat_reg == STAT_OK) &&
                         (insub_reg ? act_reg[len_reg] : closed[len_reg]);
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            esc_reg   <= 1'b0;
            stat_reg  <= STAT_OK;
            act_reg   <= '0;
            insub_reg <= 1'b0;
        end else begin
            len_reg   <= len_next;
            esc_reg   <= esc_next;
            stat_reg  <= stat_next;
            act_reg   <= act_next;
            insub_reg <= insub_next;
        end
    end

    // Store a new element at the end of the pattern
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            kind_reg[len_reg[IdxW-1:0]] <= add_kind;
            lit_reg[len_reg[IdxW-1:0]]  <= cmd.cp;
        end
    end

endmodule

// ===== hdl/slwm_ctrl.sv =====
module slwm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  slwm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output slwm_pkg::out_item_t m_data,
    output slwm_pkg::dp_cmd_t   cmd,
    input  slwm_pkg::out_item_t result
);
    import slwm_pkg::*;

    typedef enum logic {ST_RUN, ST_HOLD} state_t;

    state_t    state_reg, state_next;
    out_item_t data_reg, data_next;
    logic      acc;

    // Take a transaction unless a result waits in the output register and m_ready is low
    assign s_ready = (state_reg == ST_RUN) || m_ready;
    assign acc     = s_valid && s_ready;
    assign m_valid = (state_reg == ST_HOLD);
    assign m_data  = data_reg;

    always_comb begin
        cmd.clear = acc && s_data.mode == MODE_CLEAR;
        cmd.pat   = acc && s_data.mode == MODE_PAT;
        cmd.subj  = acc && s_data.mode == MODE_SUBJ;
        cmd.fin   = acc && s_data.mode == MODE_END;
        cmd.cp    = s_data.code_point;
    end

    always_comb begin
        state_next = state_reg;
        data_next  = data_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (cmd.fin) begin
                    state_next = ST_HOLD;
                    data_next  = result;
                end
            end
            ST_HOLD: begin
                if (cmd.fin) data_next = result;
                else if (m_ready) state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
        data_reg <= data_next;
    end

endmodule

// ===== test/slwm_checker.sv =====
// Watches both channels of the LIKE matcher, predicts each result and compares
module slwm_checker #(
    parameter int MAX_ELEMENTS = slwm_pkg::MaxElementsDef
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  slwm_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  slwm_pkg::out_item_t m_data,
    output int                  fail_count,
    output int                  pending_count,
    output int                  verdict_count
);
    import slwm_pkg::*;

    logic [1:0]           elem_kind [MAX_ELEMENTS];
    logic [CpW-1:0]       elem_cp [MAX_ELEMENTS];
    int                   pat_len;
    logic                 esc_wait;
    logic [1:0]           pat_stat;
    logic [MAX_ELEMENTS:0] live;
    logic                 subj_open;
    out_item_t            verdict_q[$];

    assign pending_count = verdict_q.size();

    // Append one compiled element, folding adjacent runs
    function automatic void add_elem(logic [1:0] kind, logic [CpW-1:0] cp);
        if (kind == KIND_RUN && pat_len > 0 && elem_kind[pat_len-1] == KIND_RUN)
            return;
        if (pat_len >= MAX_ELEMENTS) begin
            pat_stat = STAT_FULL;
            return;
        end
        elem_kind[pat_len] = kind;
        elem_cp[pat_len] = cp;
        pat_len++;
    endfunction

    function automatic void compile_char(logic [CpW-1:0] cp);
        if (pat_stat != STAT_OK)
            return;
        if (esc_wait) begin
            esc_wait = 1'b0;
            if (cp == CH_RUN || cp == CH_ONE)
                add_elem(KIND_LIT, cp);
            else
                pat_stat = STAT_BAD_ESC;
            return;
        end
        if (cp == CH_ESC) esc_wait = 1'b1;
        else if (cp == CH_RUN) add_elem(KIND_RUN, '0);
        else if (cp == CH_ONE) add_elem(KIND_ONE, '0);
        else add_elem(KIND_LIT, cp);
    endfunction

    // Pass through runs that may match nothing
    function automatic void pass_runs();
        for (int i = 0; i < pat_len; i++)
            if (live[i] && elem_kind[i] == KIND_RUN)
                live[i+1] = 1'b1;
    endfunction

    function automatic void open_subject();
        live = '0;
        live[0] = 1'b1;
        pass_runs();
        subj_open = 1'b1;
    endfunction

    function automatic void advance(logic [CpW-1:0] cp);
        logic [MAX_ELEMENTS:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
            if (!live[i]) continue;
            if (elem_kind[i] == KIND_RUN) nxt[i] = 1'b1;
            else if (elem_kind[i] == KIND_ONE) nxt[i+1] = 1'b1;
            else if (elem_cp[i] == cp) nxt[i+1] = 1'b1;
        end
        live = nxt;
        pass_runs();
    endfunction

    // Predict on accepted input, compare on accepted output
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            pat_len = 0;
            esc_wait = 1'b0;
            pat_stat = STAT_OK;
            live = '0;
            subj_open = 1'b0;
            verdict_q.delete();
            fail_count = 0;
            verdict_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                verdict_count++;
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %b/%0d", m_data.matched,
                                 m_data.status);
                end else begin
                    want = verdict_q.pop_front();
                    if (want !== m_data) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected matched=%b status=%0d, got %b/%0d",
                                     want.matched, want.status, m_data.matched,
                                     m_data.status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_data.mode)
                    MODE_CLEAR: begin
                        pat_len = 0;
                        esc_wait = 1'b0;
                        pat_stat = STAT_OK;
                        live = '0;
                        subj_open = 1'b0;
                    end
                    MODE_PAT: begin
                        compile_char(s_data.code_point);
                        live = '0;
                        subj_open = 1'b0;
                    end
                    MODE_SUBJ: begin
                        if (!subj_open) open_subject();
                        advance(s_data.code_point);
                    end
                    default: begin
                        if (!subj_open) open_subject();
                        want.matched = (pat_stat == STAT_OK) && live[pat_len];
                        want.status = pat_stat;
                        verdict_q.push_back(want);
                        live = '0;
                        subj_open = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import slwm_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    int        fail_count, pending_count, verdict_count;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_cycles = 0;
    int        item_count = 0;

    sql_like_wildcard_matcher uut (.*);

    slwm_checker chk (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Drive m_ready: long hold-off when asked, else random stalls
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one transaction and wait for its acceptance; valid stays up after
    always_comb begin end
    task automatic send(logic [1:0] mode, logic [CpW-1:0] cp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{mode: mode, code_point: cp};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        item_count++;
    endtask

    task automatic send_text(string str, logic [1:0] mode);
        for (int i = 0; i < str.len(); i++)
            send(mode, CpW'(str[i]));
    endtask

    // Pick a pattern character biased toward wildcards and escapes
    function automatic logic [CpW-1:0] pick_pat_char();
        case ($urandom_range(9))
            0, 1: return CH_RUN;
            2: return CH_ONE;
            3: return CH_ESC;
            4: return CpW'($urandom());
            default: return CpW'($urandom_range(3) + 'h61);
        endcase
    endfunction

    function automatic logic [CpW-1:0] pick_subj_char();
        if ($urandom_range(9) == 0) return CpW'($urandom());
        if ($urandom_range(9) == 0) return CH_RUN;
        return CpW'($urandom_range(3) + 'h61);
    endfunction

    task automatic random_phase(int n);
        int plen, slen;
        while (n > 0) begin
            if ($urandom_range(9) != 0) send(MODE_CLEAR, CpW'($urandom()));
            plen = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(8);
            for (int i = 0; i < plen; i++) send(MODE_PAT, pick_pat_char());
            for (int s = 0; s < 4; s++) begin
                slen = $urandom_range(8);
                for (int i = 0; i < slen; i++) send(MODE_SUBJ, pick_subj_char());
                if ($urandom_range(15) == 0) send(MODE_PAT, pick_pat_char());
                send(MODE_END, CpW'($urandom()));
            end
            n -= plen + 20;
        end
    endtask

    // Drop valid and wait for every expected result
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty subject on empty pattern, extremes of code point
        send(MODE_END, '0);
        send(MODE_SUBJ, '1);
        send(MODE_END, '1);
        send(MODE_PAT, '1);
        send(MODE_PAT, '0);
        send(MODE_SUBJ, '1);
        send(MODE_SUBJ, '0);
        send(MODE_END, '0);
        // Adjacent runs, an escaped wildcard, trailing literal
        send(MODE_CLEAR, '1);
        send_text("a%%\\%_b", MODE_PAT);
        send_text("axy%zb", MODE_SUBJ);
        send(MODE_END, '0);
        send_text("ax%zbq", MODE_SUBJ);
        send(MODE_END, '0);
        // Bad escape, then trailing lone backslash
        send(MODE_CLEAR, '0);
        send_text("\\\\", MODE_PAT);
        send(MODE_END, '0);
        send(MODE_CLEAR, '0);
        send_text("x\\", MODE_PAT);
        send(MODE_SUBJ, CpW'("x"));
        send(MODE_END, '0);
        // Store overflow
        send(MODE_CLEAR, '0);
        for (int i = 0; i < MaxElementsDef + 1; i++) send(MODE_PAT, CH_ONE);
        send(MODE_END, '0);
        wait_drained();

        // Receiver holds off while further subject ends wait at the input
        hold_cycles = 200;
        send(MODE_CLEAR, '0);
        repeat (10) send(MODE_END, '0);
        wait_drained();

        send_idle_pct = 6;
        recv_idle_pct = 57;
        random_phase(350);
        wait_drained();
        send_idle_pct = 57;
        recv_idle_pct = 6;
        random_phase(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d transactions in, %0d results: wildcards, escapes, overflow,",
                 item_count, verdict_count);
        $display("stalls on both channels and a long output hold-off.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
